@@ src/bis_pkg.sv @@
// Shared constants, codes and the queued item type of the bilinear image sampler.
`default_nettype none

package bis_pkg;

  localparam int MAX_COLS     = 256;
  localparam int MAX_ROWS     = 256;
  localparam int FRAC_BITS    = 8;
  localparam int SAMPLE_BITS  = 16;
  localparam int COORD_BITS   = 18;
  localparam int SIZE_BITS    = 9;
  localparam int POS_BITS     = 8;
  localparam int CFG_IDX_BITS = 4;

  localparam int COL_BITS      = $clog2(MAX_COLS);
  localparam int ROW_BITS      = $clog2(MAX_ROWS);
  localparam int INT_BITS      = COORD_BITS - FRAC_BITS;
  localparam int BANK_SEL_BITS = 2;
  localparam int NUM_BANKS     = 4;
  localparam int BANK_AW       = COL_BITS + ROW_BITS - 2;
  localparam int QUEUE_DEPTH   = 2;

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_SAMPLE = 1'b1
  } opcode_e;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_GRID_WIDTH  = 4'd0,
    CFG_GRID_HEIGHT = 4'd1
  } cfg_idx_e;

  // One decoded item between front and back. Banks are indexed {row[0], col[0]}.
  typedef struct packed {
    logic                                 is_sample;
    logic [BANK_SEL_BITS-1:0]             wr_bank;
    logic [NUM_BANKS-1:0][BANK_AW-1:0]    addr;
    logic signed [SAMPLE_BITS-1:0]        wr_value;
    logic [FRAC_BITS-1:0]                 fx;
    logic [FRAC_BITS-1:0]                 fy;
    logic                                 x0_odd;
    logic                                 x1_odd;
    logic                                 y0_odd;
    logic                                 y1_odd;
  } item_t;

endpackage

`default_nettype wire

@@ src/bis_if.sv @@
// Handshake channel interfaces: request, response and configuration write.
`default_nettype none

interface bis_req_if;
  logic                                   valid;
  logic                                   ready;
  logic                                   opcode;
  logic [bis_pkg::POS_BITS-1:0]           write_col;
  logic [bis_pkg::POS_BITS-1:0]           write_row;
  logic signed [bis_pkg::SAMPLE_BITS-1:0] write_value;
  logic signed [bis_pkg::COORD_BITS-1:0]  coord_x;
  logic signed [bis_pkg::COORD_BITS-1:0]  coord_y;

  modport source (output valid, opcode, write_col, write_row, write_value, coord_x, coord_y,
                  input ready);
  modport sink (input valid, opcode, write_col, write_row, write_value, coord_x, coord_y,
                output ready);
endinterface

interface bis_rsp_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [bis_pkg::SAMPLE_BITS-1:0] sample_value;

  modport source (output valid, sample_value, input ready);
  modport sink (input valid, sample_value, output ready);
endinterface

interface bis_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [bis_pkg::CFG_IDX_BITS-1:0]  index;
  logic [bis_pkg::SIZE_BITS-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ src/bis_front.sv @@
// Front end: size registers, item decode, axis clamping and bank address generation.
`default_nettype none

module bis_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  bis_cfg_if.sink            cfg_i,
  bis_req_if.sink            req_i,
  output bis_pkg::item_t     push_item_o,
  output logic               push_valid_o,
  input  wire logic          push_ready_i
);

  typedef struct packed {
    logic [bis_pkg::COL_BITS-1:0]  i0;
    logic [bis_pkg::COL_BITS-1:0]  i1;
    logic [bis_pkg::FRAC_BITS-1:0] frac;
  } axis_t;

  logic [bis_pkg::SIZE_BITS-1:0] width_q, width_d;
  logic [bis_pkg::SIZE_BITS-1:0] height_q, height_d;

  // Size register to highest usable index: zero acts as 1, oversize as the maximum.
  function automatic logic [bis_pkg::COL_BITS-1:0] eff_hi(
    input logic [bis_pkg::SIZE_BITS-1:0] sz,
    input int                            max_sz
  );
    logic [bis_pkg::SIZE_BITS-1:0] r;
    if (sz == '0) begin
      r = '0;
    end else if (sz > bis_pkg::SIZE_BITS'(max_sz)) begin
      r = bis_pkg::SIZE_BITS'(max_sz - 1);
    end else begin
      r = sz - 1'b1;
    end
    return r[bis_pkg::COL_BITS-1:0];
  endfunction

  function automatic logic [bis_pkg::COL_BITS-1:0] clamp(
    input logic signed [bis_pkg::INT_BITS:0] v,
    input logic [bis_pkg::COL_BITS-1:0]      hi
  );
    logic [bis_pkg::COL_BITS-1:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > $signed({{(bis_pkg::INT_BITS+1-bis_pkg::COL_BITS){1'b0}}, hi})) begin
      r = hi;
    end else begin
      r = v[bis_pkg::COL_BITS-1:0];
    end
    return r;
  endfunction

  // floor/ceil neighbours, clamped; fraction dropped when both land on one cell
  function automatic axis_t axis(
    input logic signed [bis_pkg::COORD_BITS-1:0] c,
    input logic [bis_pkg::COL_BITS-1:0]          hi
  );
    logic signed [bis_pkg::INT_BITS:0] fl;
    logic signed [bis_pkg::INT_BITS:0] ce;
    logic [bis_pkg::FRAC_BITS-1:0]     f;
    axis_t                             r;
    f    = c[bis_pkg::FRAC_BITS-1:0];
    fl   = (bis_pkg::INT_BITS+1)'($signed(c[bis_pkg::COORD_BITS-1:bis_pkg::FRAC_BITS]));
    ce   = fl + (bis_pkg::INT_BITS+1)'(f != '0);
    r.i0 = clamp(fl, hi);
    r.i1 = clamp(ce, hi);
    r.frac = (r.i0 == r.i1) ? '0 : f;
    return r;
  endfunction

  assign cfg_i.ready = 1'b1;

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    if (cfg_i.valid) begin
      case (cfg_i.index)
        bis_pkg::CFG_GRID_WIDTH:  width_d  = cfg_i.data;
        bis_pkg::CFG_GRID_HEIGHT: height_d = cfg_i.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= bis_pkg::SIZE_BITS'(bis_pkg::MAX_COLS);
      height_q <= bis_pkg::SIZE_BITS'(bis_pkg::MAX_ROWS);
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
    end
  end

  axis_t ax, ay;
  logic  [bis_pkg::COL_BITS-1:0] col_sel;
  logic  [bis_pkg::ROW_BITS-1:0] row_sel;

  always_comb begin
    ax = axis(req_i.coord_x, eff_hi(width_q, bis_pkg::MAX_COLS));
    ay = axis(req_i.coord_y, eff_hi(height_q, bis_pkg::MAX_ROWS));
    col_sel = '0;
    row_sel = '0;

    push_item_o           = '0;
    push_item_o.is_sample = (req_i.opcode == bis_pkg::OP_SAMPLE);
    push_item_o.wr_bank   = {req_i.write_row[0], req_i.write_col[0]};
    push_item_o.wr_value  = req_i.write_value;
    push_item_o.fx        = ax.frac;
    push_item_o.fy        = ay.frac;
    push_item_o.x0_odd    = ax.i0[0];
    push_item_o.x1_odd    = ax.i1[0];
    push_item_o.y0_odd    = ay.i0[0];
    push_item_o.y1_odd    = ay.i1[0];

    for (int b = 0; b < bis_pkg::NUM_BANKS; b++) begin
      if (push_item_o.is_sample) begin
        // each parity bank serves whichever neighbour has its parity
        col_sel = (ax.i0[0] == b[0]) ? ax.i0 : ax.i1;
        row_sel = (ay.i0[0] == b[1]) ? ay.i0 : ay.i1;
        push_item_o.addr[b] = {row_sel[bis_pkg::ROW_BITS-1:1], col_sel[bis_pkg::COL_BITS-1:1]};
      end else begin
        // the store spans every position the write fields can name
        push_item_o.addr[b] = {req_i.write_row[bis_pkg::POS_BITS-1:1],
                               req_i.write_col[bis_pkg::POS_BITS-1:1]};
      end
    end
  end

  assign push_valid_o = req_i.valid;
  assign req_i.ready  = push_ready_i;

endmodule

`default_nettype wire

@@ src/bis_queue.sv @@
// Short FIFO of decoded items between front end and back end.
`default_nettype none

module bis_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_valid_i,
  output logic                 push_ready_o,
  input  wire bis_pkg::item_t  push_item_i,
  output logic                 pop_valid_o,
  input  wire logic            pop_ready_i,
  output bis_pkg::item_t       pop_item_o
);

  localparam int PTR_W = (bis_pkg::QUEUE_DEPTH > 1) ? $clog2(bis_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(bis_pkg::QUEUE_DEPTH + 1);

  bis_pkg::item_t   entries_q [bis_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             push, pop;

  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(bis_pkg::QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign push_ready_o = (count_q != CNT_W'(bis_pkg::QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_item_o   = entries_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = push ? next_ptr(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop ? next_ptr(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q + CNT_W'(push) - CNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entries_q[wr_ptr_q] <= push_item_i;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(bis_pkg::QUEUE_DEPTH))
    else $error("queue fill count above depth");

  a_push_only_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> (count_q == $past(count_q) + 1'b1))
    else $error("queue count did not grow on a lone push");

endmodule

`default_nettype wire

@@ src/bis_back.sv @@
// Back end: four parity banks of the grid, two lerp stages, rounding and output register.
`default_nettype none

module bis_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            pop_valid_i,
  output logic                 pop_ready_o,
  input  wire bis_pkg::item_t  pop_item_i,
  bis_rsp_if.source            rsp_o
);

  localparam int BANK_DEPTH = 2 ** bis_pkg::BANK_AW;
  localparam int WB         = bis_pkg::FRAC_BITS + 1;
  localparam int LW         = bis_pkg::SAMPLE_BITS + bis_pkg::FRAC_BITS + 2;
  localparam int SW         = bis_pkg::SAMPLE_BITS + 2 * bis_pkg::FRAC_BITS + 1;
  localparam int SH         = 2 * bis_pkg::FRAC_BITS;
  localparam int RW         = SW - SH + 1;
  localparam logic [WB-1:0] W_ONE = WB'(1 << bis_pkg::FRAC_BITS);
  localparam logic signed [RW-1:0] SMAX = RW'((1 << (bis_pkg::SAMPLE_BITS - 1)) - 1);
  localparam logic signed [RW-1:0] SMIN = ~SMAX;

  logic en, issue;

  // whole back pipeline moves together; it freezes only when a result is held
  assign en          = !rsp_o.valid || rsp_o.ready;
  assign issue       = en && pop_valid_i;
  assign pop_ready_o = en;

  // ---- stage 1: bank access ----
  logic signed [bis_pkg::SAMPLE_BITS-1:0] rd_data_q [bis_pkg::NUM_BANKS];

  for (genvar b = 0; b < bis_pkg::NUM_BANKS; b++) begin : g_bank
    logic signed [bis_pkg::SAMPLE_BITS-1:0] bank_mem_q [BANK_DEPTH];

    always_ff @(posedge clk_i) begin
      if (issue && !pop_item_i.is_sample &&
          (pop_item_i.wr_bank == bis_pkg::BANK_SEL_BITS'(b))) begin
        bank_mem_q[pop_item_i.addr[b]] <= pop_item_i.wr_value;
      end
      if (en) begin
        rd_data_q[b] <= bank_mem_q[pop_item_i.addr[b]];
      end
    end
  end

  logic                          s1_valid_q, s2_valid_q, s3_valid_q, out_valid_q;
  logic [bis_pkg::FRAC_BITS-1:0] s1_fx_q, s1_fy_q, s2_fy_q;
  logic                          s1_x0_odd_q, s1_x1_odd_q, s1_y0_odd_q, s1_y1_odd_q;

  // ---- stage 2: horizontal lerp of both rows ----
  logic signed [bis_pkg::SAMPLE_BITS-1:0] v00, v10, v01, v11;
  logic [WB-1:0]                          wx0, wy0;
  logic signed [LW-1:0]                   top_d, bot_d, top_q, bot_q;

  always_comb begin
    v00   = rd_data_q[{s1_y0_odd_q, s1_x0_odd_q}];
    v10   = rd_data_q[{s1_y0_odd_q, s1_x1_odd_q}];
    v01   = rd_data_q[{s1_y1_odd_q, s1_x0_odd_q}];
    v11   = rd_data_q[{s1_y1_odd_q, s1_x1_odd_q}];
    wx0   = W_ONE - {1'b0, s1_fx_q};
    top_d = LW'($signed({1'b0, wx0})) * LW'(v00) + LW'($signed({1'b0, s1_fx_q})) * LW'(v10);
    bot_d = LW'($signed({1'b0, wx0})) * LW'(v01) + LW'($signed({1'b0, s1_fx_q})) * LW'(v11);
  end

  // ---- stage 3: vertical lerp ----
  logic signed [SW-1:0] sum_d, sum_q;

  always_comb begin
    wy0   = W_ONE - {1'b0, s2_fy_q};
    sum_d = SW'($signed({1'b0, wy0})) * SW'(top_q) + SW'($signed({1'b0, s2_fy_q})) * SW'(bot_q);
  end

  // ---- output: round half up, saturate ----
  logic signed [RW-1:0]                   round;
  logic signed [bis_pkg::SAMPLE_BITS-1:0] out_data_d, out_data_q;

  always_comb begin
    round = RW'(sum_q >>> SH) + RW'(sum_q[SH-1]);
    if (round > SMAX) begin
      out_data_d = SMAX[bis_pkg::SAMPLE_BITS-1:0];
    end else if (round < SMIN) begin
      out_data_d = SMIN[bis_pkg::SAMPLE_BITS-1:0];
    end else begin
      out_data_d = round[bis_pkg::SAMPLE_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q  <= issue && pop_item_i.is_sample;
      s2_valid_q  <= s1_valid_q;
      s3_valid_q  <= s2_valid_q;
      out_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_fx_q     <= pop_item_i.fx;
      s1_fy_q     <= pop_item_i.fy;
      s1_x0_odd_q <= pop_item_i.x0_odd;
      s1_x1_odd_q <= pop_item_i.x1_odd;
      s1_y0_odd_q <= pop_item_i.y0_odd;
      s1_y1_odd_q <= pop_item_i.y1_odd;
      top_q       <= top_d;
      bot_q       <= bot_d;
      s2_fy_q     <= s1_fy_q;
      sum_q       <= sum_d;
      out_data_q  <= out_data_d;
    end
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.sample_value = out_data_q;

  a_write_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (issue && !pop_item_i.is_sample) |=> !s1_valid_q)
    else $error("write item entered the result pipeline");

  a_stall_freezes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable({s1_valid_q, s2_valid_q, s3_valid_q, out_valid_q}))
    else $error("back pipeline moved while output stalled");

  a_blend_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s3_valid_q |-> ((round <= SMAX) && (round >= SMIN)))
    else $error("rounded blend left the sample range");

endmodule

`default_nettype wire

@@ src/bilinear_image_sampler.sv @@
// Top level of the bilinear image sampler: front end, item queue and back end.
//
//   channel  role    carries                                          moves on
//   cfg_i    sink    index, data (grid_width / grid_height)           valid & ready
//   req_i    sink    opcode, write_col/row/value, coord_x/y           valid & ready
//   rsp_o    source  sample_value                                     valid & ready
//
// One item per cycle sustained while rsp_o does not stall; a request passes the queue
// entry, the bank read, horizontal lerp, vertical lerp and output registers in turn.
// A write gives no result. The rate is set by the four grid banks (row/column parity),
// which deliver all four neighbours in one access.
// Reset sets both size registers to 256; the grid store itself is not cleared.
// A stalled rsp_o freezes the back pipeline; the 2-entry queue takes up to two more
// req_i transfers before req_i stalls.
// Configuration writes take effect on the next cycle and are always accepted.
`default_nettype none

module bilinear_image_sampler (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  bis_cfg_if.sink    cfg_i,
  bis_req_if.sink    req_i,
  bis_rsp_if.source  rsp_o
);

  bis_pkg::item_t push_item, pop_item;
  logic           push_valid, push_ready;
  logic           pop_valid, pop_ready;

  // decode + clamp; items are classified before they are queued
  bis_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_i),
    .req_i        (req_i),
    .push_item_o  (push_item),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready)
  );

  // writes and samples stay in order through the queue, so a sample
  // always sees every write transferred before it
  bis_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_item_i  (push_item),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_item_o   (pop_item)
  );

  // bank access, two-stage lerp, round/saturate, output register
  bis_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_item_i  (pop_item),
    .rsp_o       (rsp_o)
  );

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
// Self-checking testbench for the bilinear image sampler: directed table, then random phases.
`timescale 1ns / 100ps

module tb_top;
  import bis_pkg::*;

  // Run shape
  localparam int PHASES        = 7;
  localparam int PHASE_ITEMS   = 170;   // items per random phase, fill writes included
  localparam int DRAIN_CYCLES  = 16;    // covers the pipeline and the 2-entry queue, with margin
  localparam int LONG_HOLD     = 400;   // response hold-off, long enough to back up req_i
  localparam int STALL_LIMIT   = 3000;  // cycles with no transfer on any channel
  localparam int REPORT_LIMIT  = 10;
  localparam int GRID_CELLS    = MAX_COLS * MAX_ROWS;
  localparam int FRAC_MASK     = (1 << FRAC_BITS) - 1;
  localparam int ONE           = 1 << FRAC_BITS;

  // Register index outside the list; writes to it must not disturb the sizes.
  localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_SPARE = 4'hF;

  localparam logic signed [COORD_BITS-1:0]  COORD_MIN  = 18'sh20000;
  localparam logic signed [COORD_BITS-1:0]  COORD_MAX  = 18'sh1FFFF;
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = 16'sh8000;
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = 16'sh7FFF;

  typedef struct {
    opcode_e                        op;
    logic [POS_BITS-1:0]            col;
    logic [POS_BITS-1:0]            row;
    logic signed [SAMPLE_BITS-1:0]  value;
    logic signed [COORD_BITS-1:0]   cx;
    logic signed [COORD_BITS-1:0]   cy;
    bit                             has_lit;  // expected value typed into the table
    logic signed [SAMPLE_BITS-1:0]  lit;
  } request_t;

  // Directed part, issued right after reset with both sizes at 256.
  // Corners first, then the coordinate extremes (which clamp onto the corners),
  // a rounding tie, interior fractions and alternating bit patterns.
  localparam int DIRECTED_ROWS = 20;
  request_t directed [DIRECTED_ROWS] = '{
    '{OP_WRITE,  8'd0,   8'd0,   SAMPLE_MIN,  18'sd0,      18'sd0,      1'b0, 16'sd0},
    '{OP_WRITE,  8'd255, 8'd0,   SAMPLE_MAX,  18'sd0,      18'sd0,      1'b0, 16'sd0},
    '{OP_WRITE,  8'd0,   8'd255, 16'sh1234,   18'sd0,      18'sd0,      1'b0, 16'sd0},
    '{OP_WRITE,  8'd255, 8'd255, -16'sd1,     18'sd0,      18'sd0,      1'b0, 16'sd0},
    '{OP_SAMPLE, 8'd0,   8'd0,   16'sd0,      18'sd0,      18'sd0,      1'b1, SAMPLE_MIN},
    '{OP_SAMPLE, 8'hFF,  8'hFF,  16'shFFFF,   COORD_MIN,   COORD_MIN,   1'b1, SAMPLE_MIN},
    '{OP_SAMPLE, 8'd0,   8'd0,   16'sd0,      COORD_MAX,   COORD_MIN,   1'b1, SAMPLE_MAX},
    '{OP_SAMPLE, 8'd0,   8'd0,   16'sd0,      COORD_MIN,   COORD_MAX,   1'b1, 16'sh1234},
    '{OP_SAMPLE, 8'd0,   8'd0,   16'sd0,      COORD_MAX,   COORD_MAX,   1'b1, -16'sd1},
    '{OP_WRITE,  8'd1,   8'd0,   SAMPLE_MAX,  18'sd0,      18'sd0,      1'b0, 16'sd0},
    '{OP_SAMPLE, 8'd0,   8'd0,   16'sd0,      18'sh00080,  18'sd0,      1'b0, 16'sd0},
    '{OP_WRITE,  8'd0,   8'd1,   16'sd100,    18'sd0,      18'sd0,      1'b0, 16'sd0},
    '{OP_WRITE,  8'd1,   8'd1,   -16'sd100,   18'sd0,      18'sd0,      1'b0, 16'sd0},
    '{OP_SAMPLE, 8'd0,   8'd0,   16'sd0,      18'sh000FF,  18'sh000FF,  1'b0, 16'sd0},
    '{OP_SAMPLE, 8'd0,   8'd0,   16'sd0,      18'sh00040,  18'sh000C0,  1'b0, 16'sd0},
    '{OP_WRITE,  8'hAA,  8'h55,  16'sh5555,   18'sh15555,  18'sh2AAAA,  1'b0, 16'sd0},
    '{OP_WRITE,  8'h55,  8'hAA,  16'shAAAA,   18'sh2AAAA,  18'sh15555,  1'b0, 16'sd0},
    '{OP_SAMPLE, 8'd0,   8'd0,   16'sd0,      18'sh0AA00,  18'sh05500,  1'b1, 16'sh5555},
    '{OP_SAMPLE, 8'd0,   8'd0,   16'sd0,      -18'sd128,   18'sd0,      1'b1, SAMPLE_MIN},
    '{OP_SAMPLE, 8'd0,   8'd0,   16'sd0,      18'sh0FF80,  18'sd0,      1'b1, SAMPLE_MAX}
  };

  logic clk = 1'b0;
  logic rst_n;

  bis_cfg_if cfg_if ();
  bis_req_if req_if ();
  bis_rsp_if rsp_if ();

  bilinear_image_sampler u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cfg_i  (cfg_if),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor state, owned by the monitor and updated on reset and on observed transfers
  // ---------------------------------------------------------------------------
  logic signed [SAMPLE_BITS-1:0] grid_model [GRID_CELLS];
  logic [SIZE_BITS-1:0]          model_w;
  logic [SIZE_BITS-1:0]          model_h;
  logic signed [SAMPLE_BITS-1:0] expected_samples [$];
  request_t                      sample_tags [$];  // one per issued sample, in order

  // Stimulus side bookkeeping
  bit                   written_cells [GRID_CELLS];
  logic [SIZE_BITS-1:0] drv_w = 9'd256;
  logic [SIZE_BITS-1:0] drv_h = 9'd256;
  int                   requests_sent = 0;
  int                   samples_sent  = 0;
  int                   results_seen  = 0;
  int                   fail_count    = 0;
  int                   src_idle_pct  = 0;
  int                   sink_idle_pct = 0;
  int                   hold_requests = 0;

  // Out-of-range size registers act as 1 or as the maximum.
  function automatic int eff_size(logic [SIZE_BITS-1:0] r, int maxv);
    if (r < 1) return 1;
    if (r > maxv) return maxv;
    return int'(r);
  endfunction

  function automatic int clamp_idx(int v, int size);
    if (v < 0) return 0;
    if (v > size - 1) return size - 1;
    return v;
  endfunction

  // Floor/ceil neighbours of one axis, clamped to the grid. When clamping folds
  // both onto one cell the fraction is dropped, which yields the edge sample.
  function automatic void split_axis(input logic signed [COORD_BITS-1:0] c, input int size,
                                     output int lo, output int hi, output int frac);
    int ci;
    int f;
    int fl;
    ci   = c;
    f    = ci & FRAC_MASK;
    fl   = ci >>> FRAC_BITS;
    lo   = clamp_idx(fl, size);
    hi   = clamp_idx(fl + ((f != 0) ? 1 : 0), size);
    frac = (lo == hi) ? 0 : f;
  endfunction

  function automatic longint grid_at(int x, int y);
    return longint'(grid_model[y * MAX_COLS + x]);
  endfunction

  // Weighted sum scaled by 2^(2F), rounded half up, saturated to the sample range.
  function automatic logic signed [SAMPLE_BITS-1:0] interpolate(
      logic signed [COORD_BITS-1:0] cx, logic signed [COORD_BITS-1:0] cy);
    int     x0, x1, y0, y1, fx, fy;
    longint upper, lower, acc, q;
    split_axis(cx, eff_size(model_w, MAX_COLS), x0, x1, fx);
    split_axis(cy, eff_size(model_h, MAX_ROWS), y0, y1, fy);
    upper = longint'(ONE - fx) * grid_at(x0, y0) + longint'(fx) * grid_at(x1, y0);
    lower = longint'(ONE - fx) * grid_at(x0, y1) + longint'(fx) * grid_at(x1, y1);
    acc   = longint'(ONE - fy) * upper + longint'(fy) * lower;
    q     = acc >>> (2 * FRAC_BITS);
    if (acc[2 * FRAC_BITS - 1]) q = q + 1;
    if (q > longint'(SAMPLE_MAX)) q = longint'(SAMPLE_MAX);
    if (q < longint'(SAMPLE_MIN)) q = longint'(SAMPLE_MIN);
    return SAMPLE_BITS'(q);
  endfunction

  task automatic note_failure(string what, logic signed [SAMPLE_BITS-1:0] want,
                              logic signed [SAMPLE_BITS-1:0] got);
    fail_count++;
    if (fail_count <= REPORT_LIMIT)
      $display("%0t: %s: sample_value expected %0d, got %0d", $time, what, want, got);
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: tracks config and grid writes, predicts samples, checks results.
  // Results are checked before a same-edge request is queued, since a request
  // can never produce its result in the cycle it is accepted.
  // ---------------------------------------------------------------------------
  int idle_run = 0;

  always @(posedge clk) begin : monitor
    logic signed [SAMPLE_BITS-1:0] want;
    request_t                      tag;
    bit                            moved;
    moved = 1'b0;
    if (!rst_n) begin
      model_w = 9'd256;
      model_h = 9'd256;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        moved = 1'b1;
        results_seen++;
        if (expected_samples.size() == 0) begin
          note_failure("unexpected result", 'x, rsp_if.sample_value);
        end else begin
          want = expected_samples.pop_front();
          if (rsp_if.sample_value !== want)
            note_failure("wrong result", want, rsp_if.sample_value);
        end
      end
      if (cfg_if.valid && cfg_if.ready) begin
        moved = 1'b1;
        case (cfg_if.index)
          CFG_GRID_WIDTH:  model_w = cfg_if.data;
          CFG_GRID_HEIGHT: model_h = cfg_if.data;
          default: ;  // unlisted index: no effect
        endcase
      end
      if (req_if.valid && req_if.ready) begin
        moved = 1'b1;
        if (req_if.opcode == OP_WRITE) begin
          grid_model[int'(req_if.write_row) * MAX_COLS + int'(req_if.write_col)] =
            req_if.write_value;
        end else begin
          tag = sample_tags.pop_front();
          want = tag.has_lit ? tag.lit : interpolate(req_if.coord_x, req_if.coord_y);
          expected_samples = {expected_samples, want};
        end
      end
    end
    // Watchdog: a run with no transfer for this long is hung.
    idle_run = moved ? 0 : idle_run + 1;
    if (idle_run >= STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
      $display("bilinear_image_sampler: mismatch");
      $finish;
    end
  end

  // Response side: random back-pressure, plus a long hold-off on request so the
  // queue and pipeline fill up and req_i stalls while the sender keeps offering.
  int hold_left   = 0;
  int holds_taken = 0;

  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      rsp_if.ready <= 1'b0;
    end else if (holds_taken != hold_requests) begin
      holds_taken++;
      hold_left = LONG_HOLD;
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  // One request transfer. Writes mark their cell as loaded when issued, so a later
  // sample in the stream never reads a cell that was never written.
  task automatic issue_request(request_t r);
    if (r.op == OP_WRITE) written_cells[int'(r.row) * MAX_COLS + int'(r.col)] = 1'b1;
    else begin
      sample_tags = {sample_tags, r};
      samples_sent++;
    end
    while ($urandom_range(99) < src_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid       <= 1'b1;
    req_if.opcode      <= r.op;
    req_if.write_col   <= r.col;
    req_if.write_row   <= r.row;
    req_if.write_value <= r.value;
    req_if.coord_x     <= r.cx;
    req_if.coord_y     <= r.cy;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    requests_sent++;
  endtask

  // Caller lowers valid after the last write of a batch.
  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [SIZE_BITS-1:0] d);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= d;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    if (idx == CFG_GRID_WIDTH) drv_w = d;
    else if (idx == CFG_GRID_HEIGHT) drv_h = d;
  endtask

  // Writes give no result, so let the pipeline empty after the last sample.
  task automatic wait_drained();
    while (results_seen != samples_sent) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic signed [SAMPLE_BITS-1:0] rand_sample();
    case ($urandom_range(9))
      0:       return SAMPLE_MIN;
      1:       return SAMPLE_MAX;
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  // Mostly inside the grid (often near the origin for reuse), some on and just past
  // the edges, some anywhere in the coordinate range, some at its extremes.
  function automatic logic signed [COORD_BITS-1:0] pick_coord(int size);
    int ip;
    int fr;
    int sel;
    fr  = $urandom_range(FRAC_MASK);
    sel = $urandom_range(99);
    if (sel < 30) ip = $urandom_range((size < 8) ? size - 1 : 7);
    else if (sel < 50) ip = $urandom_range(size - 1);
    else if (sel < 60) begin
      ip = $urandom_range(size - 1);
      fr = 0;
    end else if (sel < 75) begin
      case ($urandom_range(2))
        0:       ip = -1;
        1:       ip = size - 1;
        default: ip = size;
      endcase
    end else if (sel < 88) return COORD_BITS'($urandom);
    else if ($urandom_range(1)) return COORD_MIN + COORD_BITS'($urandom_range(300));
    else return COORD_MAX - COORD_BITS'($urandom_range(300));
    return COORD_BITS'(ip * ONE + fr);
  endfunction

  // One random step: a stray write, or a sample preceded by writes of any
  // neighbour cells that are still unloaded.
  task automatic random_step(int eff_w, int eff_h);
    request_t r;
    request_t fill;
    int       xs [2];
    int       ys [2];
    int       fx, fy;
    r.col     = POS_BITS'($urandom);
    r.row     = POS_BITS'($urandom);
    r.value   = rand_sample();
    r.cx      = COORD_BITS'($urandom);
    r.cy      = COORD_BITS'($urandom);
    r.has_lit = 1'b0;
    r.lit     = '0;
    if ($urandom_range(99) < 25) begin
      r.op = OP_WRITE;
      issue_request(r);
    end else begin
      r.op = OP_SAMPLE;
      r.cx = pick_coord(eff_w);
      r.cy = pick_coord(eff_h);
      split_axis(r.cx, eff_w, xs[0], xs[1], fx);
      split_axis(r.cy, eff_h, ys[0], ys[1], fy);
      for (int b = 0; b < 2; b++) begin
        for (int a = 0; a < 2; a++) begin
          if (!written_cells[ys[b] * MAX_COLS + xs[a]]) begin
            fill       = r;
            fill.op    = OP_WRITE;
            fill.col   = POS_BITS'(xs[a]);
            fill.row   = POS_BITS'(ys[b]);
            fill.value = rand_sample();
            fill.cx    = COORD_BITS'($urandom);
            fill.cy    = COORD_BITS'($urandom);
            issue_request(fill);
          end
        end
      end
      issue_request(r);
    end
  endtask

  initial begin
    logic [SIZE_BITS-1:0] ph_w, ph_h;
    int                   phase_start;
    bit                   paused;
    bit                   held;

    rst_n              = 1'b0;
    cfg_if.valid       = 1'b0;
    cfg_if.index       = '0;
    cfg_if.data        = '0;
    req_if.valid       = 1'b0;
    req_if.opcode      = OP_WRITE;
    req_if.write_col   = '0;
    req_if.write_row   = '0;
    req_if.write_value = '0;
    req_if.coord_x     = '0;
    req_if.coord_y     = '0;
    rsp_if.ready       = 1'b0;
    paused             = 1'b0;
    held               = 1'b0;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Sender idles lightly, receiver heavily.
    src_idle_pct  = 31;
    sink_idle_pct = 87;

    // Directed table at the reset sizes.
    for (int i = 0; i < DIRECTED_ROWS; i++) issue_request(directed[i]);
    req_if.valid <= 1'b0;
    wait_drained();

    for (int ph = 0; ph < PHASES; ph++) begin
      // Idling: first two phases as above, then swapped, then none at all.
      if (ph >= 4) begin
        src_idle_pct  = 0;
        sink_idle_pct = 0;
      end else if (ph >= 2) begin
        src_idle_pct  = 87;
        sink_idle_pct = 31;
      end

      // Sizes: small, single cell, zero and all-ones (used as 1 and as max),
      // random small, full grid, and above max.
      case (ph)
        0: begin ph_w = 9'd4;   ph_h = 9'd3;   end
        1: begin ph_w = 9'd1;   ph_h = 9'd1;   end
        2: begin ph_w = 9'd0;   ph_h = 9'h1FF; end
        3: begin ph_w = 9'h1FF; ph_h = 9'd0;   end
        4: begin
          ph_w = SIZE_BITS'($urandom_range(40, 2));
          ph_h = SIZE_BITS'($urandom_range(40, 2));
        end
        5: begin ph_w = 9'd256; ph_h = 9'd256; end
        default: begin
          ph_w = SIZE_BITS'($urandom_range(510, 257));
          ph_h = SIZE_BITS'($urandom_range(256, 1));
        end
      endcase

      // Unlisted index first; a wrongly decoded write to it is overwritten by the real
      // sizes, which follow.
      if (ph == 0) write_reg(CFG_IDX_SPARE, 9'h1FF);
      else write_reg(CFG_IDX_BITS'($urandom_range(15, 2)), SIZE_BITS'($urandom));
      write_reg(CFG_GRID_WIDTH, ph_w);
      write_reg(CFG_GRID_HEIGHT, ph_h);
      cfg_if.valid <= 1'b0;

      phase_start = requests_sent;
      while (requests_sent - phase_start < PHASE_ITEMS) begin
        // Sender pause mid-phase until every outstanding sample has returned.
        if (ph == 4 && !paused && requests_sent - phase_start >= PHASE_ITEMS / 2) begin
          paused = 1'b1;
          req_if.valid <= 1'b0;
          wait_drained();
        end
        // Long receiver hold-off on the full grid while requests keep coming.
        if (ph == 5 && !held && requests_sent - phase_start >= 40) begin
          held = 1'b1;
          hold_requests++;
        end
        random_step(eff_size(drv_w, MAX_COLS), eff_size(drv_h, MAX_ROWS));
      end
      req_if.valid <= 1'b0;
      wait_drained();
    end

    if (fail_count == 0) begin
      $display("bilinear_image_sampler: match");
    end else begin
      $display("bilinear_image_sampler: mismatch");
    end
    $finish;
  end

endmodule
